>>> rtl/yuyv_to_rgb_scaled_assert.svh
// Assertion macros shared by the YUYV to RGB converter.
`ifndef YUYV_TO_RGB_SCALED_ASSERT_SVH
`define YUYV_TO_RGB_SCALED_ASSERT_SVH

// Check a property on every rising clock edge outside reset.
`define YTS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check that a condition holds in the cycle after a trigger.
`define YTS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

>>> rtl/yts_pkg.sv
// Types, constants and arithmetic helpers for the YUYV to RGB converter.
package yts_pkg;

  localparam int unsigned PIX_W   = 8;
  localparam int unsigned GAIN_W  = 9;
  localparam int unsigned DIFF_W  = 9;
  localparam int unsigned COEF_W  = 14;
  localparam int unsigned PROD_W  = 21;
  localparam int unsigned SUM_W   = 22;
  localparam int unsigned FRAC_BITS  = 12;
  localparam int unsigned GAIN_SHIFT = 8;

  localparam logic signed [COEF_W-1:0] COEF_RV = 14'sd5747;
  localparam logic signed [COEF_W-1:0] COEF_GU = 14'sd1409;
  localparam logic signed [COEF_W-1:0] COEF_GV = 14'sd2925;
  localparam logic signed [COEF_W-1:0] COEF_BU = 14'sd7250;

  localparam logic [DIFF_W-1:0] CHROMA_OFFSET = 9'd128;
  localparam logic [PIX_W-1:0]  CHAN_MAX      = 8'd255;
  localparam logic [GAIN_W-1:0] GAIN_RESET    = 9'd220;

  // One YUYV macropixel.
  typedef struct packed {
    logic [PIX_W-1:0] luma_first;
    logic [PIX_W-1:0] chroma_u;
    logic [PIX_W-1:0] luma_second;
    logic [PIX_W-1:0] chroma_v;
  } yts_pix_t;

  // Luma plus the shared Q12 chroma terms.
  typedef struct packed {
    logic [PIX_W-1:0]         luma_first;
    logic [PIX_W-1:0]         luma_second;
    logic signed [PROD_W-1:0] red_term;
    logic signed [PROD_W-1:0] green_term;
    logic signed [PROD_W-1:0] blue_term;
  } yts_prod_t;

  // Two RGB pixels.
  typedef struct packed {
    logic [PIX_W-1:0] red_first;
    logic [PIX_W-1:0] green_first;
    logic [PIX_W-1:0] blue_first;
    logic [PIX_W-1:0] red_second;
    logic [PIX_W-1:0] green_second;
    logic [PIX_W-1:0] blue_second;
  } yts_rgb_t;

  // Remove the chroma offset.
  function automatic logic signed [DIFF_W-1:0] chroma_diff(input logic [PIX_W-1:0] c);
    return $signed({1'b0, c} - CHROMA_OFFSET);
  endfunction

  // Chroma difference times a Q12 coefficient.
  function automatic logic signed [PROD_W-1:0] mul_coef(
    input logic signed [DIFF_W-1:0] d,
    input logic signed [COEF_W-1:0] c
  );
    logic signed [DIFF_W+COEF_W-1:0] p;
    p = d * c;
    return p[PROD_W-1:0];
  endfunction

  // Add luma in Q12 to a chroma term, floor by 12 bits and clamp to 0..255.
  function automatic logic [PIX_W-1:0] mix_clamp(
    input logic [PIX_W-1:0]         y,
    input logic signed [PROD_W-1:0] t
  );
    logic signed [SUM_W-1:0] s;
    s = $signed({2'b00, y, {FRAC_BITS{1'b0}}}) + $signed({t[PROD_W-1], t});
    if (s[SUM_W-1]) begin
      return '0;
    end else if (s[FRAC_BITS+PIX_W]) begin
      return CHAN_MAX;
    end else begin
      return s[FRAC_BITS+PIX_W-1:FRAC_BITS];
    end
  endfunction

  // Apply the gain, truncate by 8 bits and saturate.
  function automatic logic [PIX_W-1:0] apply_gain(
    input logic [PIX_W-1:0]  v,
    input logic [GAIN_W-1:0] g
  );
    logic [PIX_W+GAIN_W-1:0] p;
    p = v * g;
    if (p[PIX_W+GAIN_W-1]) begin
      return CHAN_MAX;
    end else begin
      return p[PIX_W+GAIN_W-2:GAIN_SHIFT];
    end
  endfunction

endpackage

>>> rtl/yts_if.sv
// Channel interfaces of the YUYV to RGB converter.
interface yts_in_if;
  logic                    valid;
  logic                    ready;
  logic [yts_pkg::PIX_W-1:0] luma_first;
  logic [yts_pkg::PIX_W-1:0] chroma_u;
  logic [yts_pkg::PIX_W-1:0] luma_second;
  logic [yts_pkg::PIX_W-1:0] chroma_v;
  modport source (output valid, luma_first, chroma_u, luma_second, chroma_v, input ready);
  modport sink (input valid, luma_first, chroma_u, luma_second, chroma_v, output ready);
endinterface

interface yts_out_if;
  logic                    valid;
  logic                    ready;
  logic [yts_pkg::PIX_W-1:0] red_first;
  logic [yts_pkg::PIX_W-1:0] green_first;
  logic [yts_pkg::PIX_W-1:0] blue_first;
  logic [yts_pkg::PIX_W-1:0] red_second;
  logic [yts_pkg::PIX_W-1:0] green_second;
  logic [yts_pkg::PIX_W-1:0] blue_second;
  modport source (output valid, red_first, green_first, blue_first,
                  red_second, green_second, blue_second, input ready);
  modport sink (input valid, red_first, green_first, blue_first,
                red_second, green_second, blue_second, output ready);
endinterface

interface yts_cfg_if;
  logic                     valid;
  logic                     ready;
  logic [yts_pkg::GAIN_W-1:0] output_gain;
  modport source (output valid, output_gain, input ready);
  modport sink (input valid, output_gain, output ready);
endinterface

>>> rtl/yts_chroma.sv
// Stage one: chroma offset removal and the Q12 chroma products.
module yts_chroma (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  yts_pkg::yts_pix_t   in_pix,
  output logic                out_valid,
  input  logic                out_ready,
  output yts_pkg::yts_prod_t  out_prod
);
  import yts_pkg::*;

  logic                     valid_r;
  yts_prod_t                prod_r;
  yts_prod_t                prod_nxt;
  logic signed [DIFF_W-1:0] du;
  logic signed [DIFF_W-1:0] dv;

  // Form the shared chroma terms.
  always_comb begin
    du = chroma_diff(in_pix.chroma_u);
    dv = chroma_diff(in_pix.chroma_v);
    prod_nxt.luma_first  = in_pix.luma_first;
    prod_nxt.luma_second = in_pix.luma_second;
    prod_nxt.red_term    = mul_coef(dv, COEF_RV);
    prod_nxt.green_term  = -(mul_coef(du, COEF_GU) + mul_coef(dv, COEF_GV));
    prod_nxt.blue_term   = mul_coef(du, COEF_BU);
  end

  assign in_ready = !valid_r || out_ready;

  // Advance when the next stage takes the item or this one is empty.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      prod_r <= prod_nxt;
    end
  end

  assign out_valid = valid_r;
  assign out_prod  = prod_r;

endmodule

>>> rtl/yts_mix.sv
// Stage two: add luma, floor the Q12 sums and clamp each channel.
module yts_mix (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  yts_pkg::yts_prod_t  in_prod,
  output logic                out_valid,
  input  logic                out_ready,
  output yts_pkg::yts_rgb_t   out_rgb
);
  import yts_pkg::*;

  logic     valid_r;
  yts_rgb_t rgb_r;
  yts_rgb_t rgb_nxt;

  // Both pixels share the chroma terms.
  always_comb begin
    rgb_nxt.red_first    = mix_clamp(in_prod.luma_first, in_prod.red_term);
    rgb_nxt.green_first  = mix_clamp(in_prod.luma_first, in_prod.green_term);
    rgb_nxt.blue_first   = mix_clamp(in_prod.luma_first, in_prod.blue_term);
    rgb_nxt.red_second   = mix_clamp(in_prod.luma_second, in_prod.red_term);
    rgb_nxt.green_second = mix_clamp(in_prod.luma_second, in_prod.green_term);
    rgb_nxt.blue_second  = mix_clamp(in_prod.luma_second, in_prod.blue_term);
  end

  assign in_ready = !valid_r || out_ready;

  // Advance when the next stage takes the item or this one is empty.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      rgb_r <= rgb_nxt;
    end
  end

  assign out_valid = valid_r;
  assign out_rgb   = rgb_r;

endmodule

>>> rtl/yts_gain.sv
// Stage three: output gain with saturation; its register drives the output.
module yts_gain (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic [yts_pkg::GAIN_W-1:0]  gain,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  yts_pkg::yts_rgb_t           in_rgb,
  output logic                        out_valid,
  input  logic                        out_ready,
  output yts_pkg::yts_rgb_t           out_rgb
);
  import yts_pkg::*;

  logic     valid_r;
  yts_rgb_t rgb_r;
  yts_rgb_t rgb_nxt;

  // Scale every channel by the gain.
  always_comb begin
    rgb_nxt.red_first    = apply_gain(in_rgb.red_first, gain);
    rgb_nxt.green_first  = apply_gain(in_rgb.green_first, gain);
    rgb_nxt.blue_first   = apply_gain(in_rgb.blue_first, gain);
    rgb_nxt.red_second   = apply_gain(in_rgb.red_second, gain);
    rgb_nxt.green_second = apply_gain(in_rgb.green_second, gain);
    rgb_nxt.blue_second  = apply_gain(in_rgb.blue_second, gain);
  end

  assign in_ready = !valid_r || out_ready;

  // Hold the result until the receiver takes it.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      rgb_r <= rgb_nxt;
    end
  end

  assign out_valid = valid_r;
  assign out_rgb   = rgb_r;

endmodule

>>> rtl/yuyv_to_rgb_scaled.sv
// Top level of the YUYV 4:2:2 macropixel to RGB888 converter with output gain.
//
// in_ch takes one YUYV macropixel per transfer (two luma samples, shared U
// and V). out_ch gives the two RGB pixels of that macropixel per transfer,
// in input order. cfg_ch writes the 9-bit output gain (numerator over 256);
// write it only while no macropixel is in flight.
//
// Three register stages: chroma products, luma add with floor and clamp,
// gain multiply with saturation. An accepted macropixel passes through the
// stage registers in that order, and the stage-three register drives
// out_ch. Throughput is one macropixel per cycle while out_ch does not stall;
// each stage has its own valid bit.
//
// Each stage moves on when it is empty or the stage after it moves, so a
// stall on out_ch fills the empty stages first and in_ch.ready drops only
// when all three hold items. Nothing is lost or repeated across a stall.
//
// Reset (rst_n low, synchronous) empties the pipeline and sets the gain to 220.
module yuyv_to_rgb_scaled (
  input  logic      clk,
  input  logic      rst_n,
  yts_in_if.sink    in_ch,
  yts_out_if.source out_ch,
  yts_cfg_if.sink   cfg_ch
);
  import yts_pkg::*;

  logic [GAIN_W-1:0] gain_r;
  yts_pix_t          in_pix;
  yts_prod_t         s1_prod;
  yts_rgb_t          s2_rgb;
  yts_rgb_t          s3_rgb;
  logic              s1_valid;
  logic              s2_valid;
  logic              s2_ready;
  logic              s3_ready;

  // Gain register, always writable.
  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gain_r <= GAIN_RESET;
    end else if (cfg_ch.valid) begin
      gain_r <= cfg_ch.output_gain;
    end
  end

  assign in_pix.luma_first  = in_ch.luma_first;
  assign in_pix.chroma_u    = in_ch.chroma_u;
  assign in_pix.luma_second = in_ch.luma_second;
  assign in_pix.chroma_v    = in_ch.chroma_v;

  yts_chroma u_chroma (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .in_pix    (in_pix),
    .out_valid (s1_valid),
    .out_ready (s2_ready),
    .out_prod  (s1_prod)
  );

  yts_mix u_mix (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (s1_valid),
    .in_ready  (s2_ready),
    .in_prod   (s1_prod),
    .out_valid (s2_valid),
    .out_ready (s3_ready),
    .out_rgb   (s2_rgb)
  );

  yts_gain u_gain (
    .clk       (clk),
    .rst_n     (rst_n),
    .gain      (gain_r),
    .in_valid  (s2_valid),
    .in_ready  (s3_ready),
    .in_rgb    (s2_rgb),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_rgb   (s3_rgb)
  );

  assign out_ch.red_first    = s3_rgb.red_first;
  assign out_ch.green_first  = s3_rgb.green_first;
  assign out_ch.blue_first   = s3_rgb.blue_first;
  assign out_ch.red_second   = s3_rgb.red_second;
  assign out_ch.green_second = s3_rgb.green_second;
  assign out_ch.blue_second  = s3_rgb.blue_second;

  `include "yuyv_to_rgb_scaled_assert.svh"

  // Input backpressure only when every stage is full and the output stalls.
  `YTS_ASSERT(a_no_bubble_stall, !in_ch.ready |-> (s1_valid && s2_valid && out_ch.valid && !out_ch.ready), "input stalled while a stage was empty")

  // An accepted item must reach the output when out_ch does not stall.
  `YTS_ASSERT_NEXT(a_latency, in_ch.valid && in_ch.ready ##1 out_ch.ready ##1 out_ch.ready, out_ch.valid, "result missing three cycles after transfer")

  // A zero gain gives black pixels.
  `YTS_ASSERT_NEXT(a_zero_gain, s2_valid && s3_ready && gain_r == '0, out_ch.red_first == '0 && out_ch.green_first == '0 && out_ch.blue_first == '0 && out_ch.red_second == '0 && out_ch.green_second == '0 && out_ch.blue_second == '0, "nonzero output with zero gain")

endmodule

>>> sim/tb_yuyv_to_rgb_scaled.sv
// Self-checking testbench for the YUYV to RGB converter with output gain.
module tb_yuyv_to_rgb_scaled;
  import yts_pkg::*;

  localparam int K_RV = 5747;
  localparam int K_GU = 1409;
  localparam int K_GV = 2925;
  localparam int K_BU = 7250;
  localparam int UV_ZERO = 128;
  localparam int PHASE_ITEMS = 50;
  localparam int NUM_PHASES = 8;
  localparam int LONG_HOLD = 60;
  localparam int CYCLE_LIMIT = 200000;

  typedef struct {
    logic [GAIN_W-1:0] gain;
    yts_pix_t          pix;
    bit                fixed;
    yts_rgb_t          rgb;
  } dir_row_t;

  // Directed rows; fixed results are read straight off the equations.
  dir_row_t dir_rows [22] = '{
    // reset gain, neutral chroma, luma extremes
    '{9'd220, {8'd0, 8'd128, 8'd255, 8'd128}, 1'b1, 48'h000000_DBDBDB},
    '{9'd220, {8'd255, 8'd128, 8'd255, 8'd128}, 1'b1, 48'hDBDBDB_DBDBDB},
    // chroma extremes
    '{9'd220, {8'd128, 8'd0, 8'd128, 8'd0}, 1'b0, 48'h0},
    '{9'd220, {8'd128, 8'd255, 8'd128, 8'd255}, 1'b0, 48'h0},
    '{9'd220, {8'd128, 8'd0, 8'd128, 8'd255}, 1'b0, 48'h0},
    '{9'd220, {8'd128, 8'd255, 8'd128, 8'd0}, 1'b0, 48'h0},
    '{9'd220, {8'd0, 8'd0, 8'd255, 8'd255}, 1'b0, 48'h0},
    '{9'd220, {8'd255, 8'd255, 8'd0, 8'd0}, 1'b0, 48'h0},
    '{9'd220, {8'h55, 8'hAA, 8'hAA, 8'h55}, 1'b0, 48'h0},
    // unity gain passes luma through
    '{9'd256, {8'd255, 8'd128, 8'd0, 8'd128}, 1'b1, 48'hFFFFFF_000000},
    '{9'd256, {8'd200, 8'd128, 8'd17, 8'd128}, 1'b1, 48'hC8C8C8_111111},
    '{9'd256, {8'd76, 8'd85, 8'd149, 8'd255}, 1'b0, 48'h0},
    '{9'd256, {8'd255, 8'd0, 8'd255, 8'd255}, 1'b0, 48'h0},
    // zero gain blanks every channel
    '{9'd0, {8'd255, 8'd0, 8'd255, 8'd255}, 1'b1, 48'h0},
    '{9'd0, {8'd128, 8'd255, 8'd200, 8'd0}, 1'b1, 48'h0},
    // largest gain saturates
    '{9'd511, {8'd255, 8'd128, 8'd1, 8'd128}, 1'b1, 48'hFFFFFF_010101},
    '{9'd511, {8'd128, 8'd128, 8'd64, 8'd128}, 1'b1, 48'hFFFFFF_7F7F7F},
    '{9'd511, {8'd0, 8'd255, 8'd0, 8'd0}, 1'b0, 48'h0},
    // smallest nonzero gain truncates to zero
    '{9'd1, {8'd255, 8'd128, 8'd255, 8'd128}, 1'b1, 48'h0},
    '{9'd1, {8'd0, 8'd0, 8'd255, 8'd255}, 1'b0, 48'h0},
    // just above the intended range
    '{9'd257, {8'd255, 8'd128, 8'd128, 8'd128}, 1'b1, 48'hFFFFFF_808080},
    '{9'd257, {8'd10, 8'd60, 8'd240, 8'd200}, 1'b0, 48'h0}
  };

  logic clk;
  logic rst_n;

  yts_in_if  pix_in ();
  yts_out_if rgb_out ();
  yts_cfg_if gain_cfg ();

  yuyv_to_rgb_scaled dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (pix_in),
    .out_ch (rgb_out),
    .cfg_ch (gain_cfg)
  );

  yts_rgb_t          rgb_expect_q [$];
  logic [GAIN_W-1:0] gain_now;
  int                cycle_count;
  int                mismatch_count;
  int                pix_sent;
  int                rgb_checked;
  int                gain_writes;
  bit                gaps_on;
  bit                long_hold_req;

  // Floor Q12 to an integer, clamp to a byte, scale by the gain, saturate.
  function automatic logic [PIX_W-1:0] scale_channel(int q12, logic [GAIN_W-1:0] g);
    int v;
    int s;
    v = q12 >>> 12;
    if (v < 0) v = 0;
    if (v > 255) v = 255;
    s = (v * int'(g)) >>> 8;
    if (s > 255) s = 255;
    return s[PIX_W-1:0];
  endfunction

  // Convert one macropixel into its two expected RGB pixels.
  function automatic yts_rgb_t rgb_from_yuyv(yts_pix_t p, logic [GAIN_W-1:0] g);
    yts_rgb_t r;
    int du;
    int dv;
    int y1;
    int y2;
    du = int'(p.chroma_u) - UV_ZERO;
    dv = int'(p.chroma_v) - UV_ZERO;
    y1 = int'(p.luma_first) << 12;
    y2 = int'(p.luma_second) << 12;
    r.red_first    = scale_channel(y1 + K_RV * dv, g);
    r.green_first  = scale_channel(y1 - K_GU * du - K_GV * dv, g);
    r.blue_first   = scale_channel(y1 + K_BU * du, g);
    r.red_second   = scale_channel(y2 + K_RV * dv, g);
    r.green_second = scale_channel(y2 - K_GU * du - K_GV * dv, g);
    r.blue_second  = scale_channel(y2 + K_BU * du, g);
    return r;
  endfunction

  // Favor the ends and the middle of the byte range now and then.
  function automatic logic [PIX_W-1:0] pick_byte();
    case ($urandom_range(0, 7))
      0: return 8'd0;
      1: return 8'd255;
      2: return 8'd128;
      default: return PIX_W'($urandom_range(0, 255));
    endcase
  endfunction

  task automatic report_mismatch(input string what);
    $display("MISMATCH cycle %0d: %s", cycle_count, what);
    mismatch_count++;
  endtask

  // Offer one macropixel and queue its expected pixels once it transfers.
  task automatic send_pix(input yts_pix_t p, input bit fixed, input yts_rgb_t fixed_rgb);
    if (gaps_on && $urandom_range(0, 5) == 0) begin
      pix_in.valid = 1'b0;
      repeat ($urandom_range(1, 10)) @(negedge clk);
    end
    pix_in.valid       = 1'b1;
    pix_in.luma_first  = p.luma_first;
    pix_in.chroma_u    = p.chroma_u;
    pix_in.luma_second = p.luma_second;
    pix_in.chroma_v    = p.chroma_v;
    do @(posedge clk); while (!pix_in.ready);
    rgb_expect_q = {rgb_expect_q, (fixed ? fixed_rgb : rgb_from_yuyv(p, gain_now))};
    pix_sent++;
    @(negedge clk);
  endtask

  // Drain the pipeline, then write the gain register.
  task automatic set_gain(input logic [GAIN_W-1:0] g);
    pix_in.valid = 1'b0;
    while (rgb_expect_q.size() != 0) @(negedge clk);
    gain_cfg.valid       = 1'b1;
    gain_cfg.output_gain = g;
    do @(posedge clk); while (!gain_cfg.ready);
    gain_now = g;
    gain_writes++;
    @(negedge clk);
    gain_cfg.valid = 1'b0;
  endtask

  // Clock.
  initial clk = 1'b0;
  always #4 clk = ~clk;

  // Watchdog.
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("tb_yuyv_to_rgb_scaled failed");
    $finish;
  end

  // Receiver: random stall bursts, one long hold-off on request.
  initial begin
    int burst_left;
    burst_left = 0;
    rgb_out.ready = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        rgb_out.ready = 1'b0;
        repeat (LONG_HOLD) @(negedge clk);
      end
      if (burst_left == 0 && gaps_on && $urandom_range(0, 5) == 0) begin
        burst_left = $urandom_range(1, 10);
      end
      if (burst_left > 0) begin
        rgb_out.ready = 1'b0;
        burst_left--;
      end else begin
        rgb_out.ready = 1'b1;
      end
    end
  end

  // Check every output transfer against the oldest expectation.
  always @(posedge clk) begin
    yts_rgb_t got;
    yts_rgb_t want;
    string    names [6];
    names = '{"blue_second", "green_second", "red_second",
              "blue_first", "green_first", "red_first"};
    if (rst_n && rgb_out.valid && rgb_out.ready) begin
      got = {rgb_out.red_first, rgb_out.green_first, rgb_out.blue_first,
             rgb_out.red_second, rgb_out.green_second, rgb_out.blue_second};
      if (rgb_expect_q.size() == 0) begin
        report_mismatch($sformatf("unexpected output %h", got));
      end else begin
        want = rgb_expect_q.pop_front();
        rgb_checked++;
        for (int i = 0; i < 6; i++) begin
          if (got[8*i +: 8] !== want[8*i +: 8]) begin
            report_mismatch($sformatf("%s got %0d want %0d", names[i],
                                      got[8*i +: 8], want[8*i +: 8]));
          end
        end
      end
    end
  end

  // Main sequence: reset, directed table, random phases, drain.
  initial begin
    yts_pix_t          p;
    logic [GAIN_W-1:0] phase_gain;
    mismatch_count = 0;
    pix_sent       = 0;
    rgb_checked    = 0;
    gain_writes    = 0;
    gaps_on        = 1'b1;
    long_hold_req  = 1'b0;
    gain_now       = GAIN_RESET;
    rst_n                = 1'b0;
    pix_in.valid         = 1'b0;
    pix_in.luma_first    = '0;
    pix_in.chroma_u      = '0;
    pix_in.luma_second   = '0;
    pix_in.chroma_v      = '0;
    gain_cfg.valid       = 1'b0;
    gain_cfg.output_gain = '0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // Walk the directed table; rewrite the gain when a row asks for another.
    foreach (dir_rows[i]) begin
      if (dir_rows[i].gain != gain_now) set_gain(dir_rows[i].gain);
      send_pix(dir_rows[i].pix, dir_rows[i].fixed, dir_rows[i].rgb);
    end

    // Random phases, each at its own gain; the last runs without idling.
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      case (ph)
        0: phase_gain = 9'd256;
        1: phase_gain = GAIN_W'($urandom_range(257, 511));
        6: phase_gain = 9'd220;
        default: phase_gain = GAIN_W'($urandom_range(0, 511));
      endcase
      set_gain(phase_gain);
      if (ph == NUM_PHASES - 1) gaps_on = 1'b0;
      if (ph == 2) long_hold_req = 1'b1;
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        p = {pick_byte(), pick_byte(), pick_byte(), pick_byte()};
        send_pix(p, 1'b0, '0);
      end
    end

    pix_in.valid = 1'b0;
    while (rgb_expect_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    $display("Covered %0d macropixels, %0d pixel pairs checked, %0d gain writes",
             pix_sent, rgb_checked, gain_writes);
    $display("Gains included reset 220, 0, 1, 256, 257 and 511, plus a long output stall");
    if (mismatch_count == 0) begin
      $display("tb_yuyv_to_rgb_scaled passed");
    end else begin
      $display("tb_yuyv_to_rgb_scaled failed");
    end
    $finish;
  end

endmodule

>>> sim.f
+incdir+rtl
rtl/yts_pkg.sv
rtl/yts_if.sv
rtl/yts_chroma.sv
rtl/yts_mix.sv
rtl/yts_gain.sv
rtl/yuyv_to_rgb_scaled.sv
sim/tb_yuyv_to_rgb_scaled.sv
